### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### rtl/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// types and constants of the size class pool allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package scpa_pkg;
  localparam logic [2:0] OUT_OK        = 3'd0;
  localparam logic [2:0] OUT_DIRECT    = 3'd1;
  localparam logic [2:0] OUT_REJECT    = 3'd2;
  localparam logic [2:0] OUT_EXHAUSTED = 3'd3;
  localparam logic [2:0] OUT_BAD       = 3'd4;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic [0:0] REG_INITIAL_GROW = 1'd0;
  localparam logic [0:0] REG_MAX_REQUEST  = 1'd1;
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DEC   = 6'b000010,
    ST_GROW  = 6'b000100,
    ST_RDREQ = 6'b001000,
    ST_RDWT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;
endpackage

### rtl/scpa_ram.sv
// ----------------------------------------------------------------------------
// scpa_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module scpa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/size_class_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// size_class_pool_allocator_core
// four size-class pools with lifo free stacks in one ram
// ----------------------------------------------------------------------------
// One word at a time. After reset a pass over all 256 entries clears the
// allocated bits, and in_stall stays high until it ends. Once a word is taken,
// a free, a rejected or a direct request passes ST_DEC and ST_DONE before its
// result shows; an allocate from a non-empty pool also passes ST_RDREQ and
// ST_RDWT, and an exhausted pool ST_RDREQ, as the free-stack ram has one port
// with a registered read. A growth of n blocks pushes one new block per cycle
// through that port in ST_GROW, then goes back to ST_RDREQ. The result is held
// in a register until it is taken. in_stall is high while busy, and the next
// word can be taken in the cycle after the result is taken.
`timescale 1ns / 1ps
module size_class_pool_allocator_core #(
  parameter int NUM_POOLS = 4,
  parameter int BLOCKS_PER_POOL = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [23:0] request_size,
  input  logic [7:0]  block_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  outcome,
  output logic [7:0]  granted_handle,
  output logic [31:0] bytes_in_use,
  output logic [31:0] peak_bytes,
  output logic [31:0] alloc_total,
  output logic [31:0] free_total,
  output logic [31:0] grow_total,
  output logic [31:0] error_total,
  output logic [31:0] direct_total
);
  localparam int BPP = BLOCKS_PER_POOL;
  localparam logic [6:0] BPP7 = 7'(BPP);

  scpa_pkg::state_t state;
  logic [6:0]  initial_grow;
  logic [23:0] max_request;
  logic [6:0]  stack_top   [NUM_POOLS];
  logic [6:0]  provisioned [NUM_POOLS];
  logic [6:0]  next_grow   [NUM_POOLS];
  logic        clearing;
  logic [7:0]  clr_addr;
  logic        cmd;
  logic [23:0] size;
  logic [7:0]  handle;
  logic [1:0]  pool;
  logic [6:0]  grow_left;
  logic        ram_we;
  logic [7:0]  ram_addr;
  logic [5:0]  ram_wdata;
  logic [5:0]  ram_rdata;
  logic        use_we;
  logic [7:0]  use_addr;
  logic        use_wdata;
  logic        use_rdata;

  scpa_ram #(.WIDTH(6), .DEPTH(256)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  scpa_ram #(.WIDTH(1), .DEPTH(256)) u_use (
    .clk(clk), .we(use_we), .addr(use_addr), .wdata(use_wdata), .rdata(use_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == scpa_pkg::REG_INITIAL_GROW) ? {25'd0, initial_grow}
                                                           : {8'd0, max_request};
  assign in_stall = clearing || (state != scpa_pkg::ST_IDLE) || out_valid;

  logic [24:0] aligned;
  logic [1:0]  fit_pool;
  logic        fits;
  logic [6:0]  ng_clamp;
  logic [6:0]  room;
  logic [6:0]  grow_n;
  logic [7:0]  ng_dbl;
  logic [31:0] cb;
  logic [1:0]  hp;
  logic [5:0]  hi;
  logic        pool_ok;
  logic        free_ok;
  always_comb begin
    aligned = (25'(size) + 25'd7) & ~25'd7;
    fits = 1'b1;
    fit_pool = 2'd0;
    if (aligned <= 25'd8) fit_pool = 2'd0;
    else if (aligned <= 25'd16) fit_pool = 2'd1;
    else if (aligned <= 25'd32) fit_pool = 2'd2;
    else if (aligned <= 25'd64) fit_pool = 2'd3;
    else fits = 1'b0;
    if (int'(fit_pool) >= NUM_POOLS) fits = 1'b0;
    ng_clamp = (next_grow[pool] == 7'd0) ? 7'd1 :
               (next_grow[pool] > BPP7) ? BPP7 : next_grow[pool];
    room = BPP7 - provisioned[pool];
    grow_n = (ng_clamp > room) ? room : ng_clamp;
    ng_dbl = {ng_clamp, 1'b0};
    cb = 32'd8 << pool;
    hp = handle[7:6];
    hi = handle[5:0];
    pool_ok = int'(hp) < NUM_POOLS;
    free_ok = pool_ok && (7'(hi) < provisioned[hp]) && use_rdata;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = {pool, stack_top[pool][5:0] - 6'd1};
    ram_wdata = provisioned[pool][5:0];
    if (state == scpa_pkg::ST_GROW) begin
      ram_we = grow_left != 7'd0;
      ram_addr = {pool, stack_top[pool][5:0]};
    end else if (state == scpa_pkg::ST_DEC && cmd == scpa_pkg::CMD_FREE) begin
      ram_we = free_ok && stack_top[hp] < 7'd64;
      ram_addr = {hp, stack_top[hp][5:0]};
      ram_wdata = hi;
    end
  end

  always_comb begin
    use_we = 1'b0;
    use_addr = block_handle;
    use_wdata = 1'b0;
    if (clearing) begin
      use_we = 1'b1;
      use_addr = clr_addr;
    end else if (state == scpa_pkg::ST_DEC && cmd == scpa_pkg::CMD_FREE) begin
      use_we = free_ok;
      use_addr = handle;
    end else if (state == scpa_pkg::ST_RDWT) begin
      use_we = 1'b1;
      use_addr = {pool, ram_rdata};
      use_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpa_pkg::ST_IDLE;
      initial_grow <= 7'd4;
      max_request <= 24'd1048576;
      for (int p = 0; p < NUM_POOLS; p++) begin
        stack_top[p] <= '0;
        provisioned[p] <= '0;
        next_grow[p] <= 7'd4;
      end
      clearing <= 1'b1;
      clr_addr <= '0;
      out_valid <= 1'b0;
      bytes_in_use <= '0;
      peak_bytes <= '0;
      alloc_total <= '0;
      free_total <= '0;
      grow_total <= '0;
      error_total <= '0;
      direct_total <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 8'd1;
        if (clr_addr == 8'hFF) clearing <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        if (paddr == 3'd0) begin
          initial_grow <= pwdata[6:0];
          for (int p = 0; p < NUM_POOLS; p++)
            if (provisioned[p] == 7'd0) next_grow[p] <= pwdata[6:0];
        end else if (paddr == 3'd4) begin
          max_request <= pwdata[23:0];
        end
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        scpa_pkg::ST_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd <= command;
            size <= request_size;
            handle <= block_handle;
            state <= scpa_pkg::ST_DEC;
          end
        end
        scpa_pkg::ST_DEC: begin
          granted_handle <= '0;
          if (cmd == scpa_pkg::CMD_FREE) begin
            if (!free_ok) begin
              outcome <= scpa_pkg::OUT_BAD;
              error_total <= error_total + 32'd1;
            end else begin
              if (stack_top[hp] < 7'd64) stack_top[hp] <= stack_top[hp] + 7'd1;
              bytes_in_use <= (bytes_in_use > (32'd8 << hp)) ?
                              bytes_in_use - (32'd8 << hp) : 32'd0;
              free_total <= free_total + 32'd1;
              granted_handle <= handle;
              outcome <= scpa_pkg::OUT_OK;
            end
            state <= scpa_pkg::ST_DONE;
          end else if (size == 24'd0 || size > max_request) begin
            outcome <= scpa_pkg::OUT_REJECT;
            error_total <= error_total + 32'd1;
            state <= scpa_pkg::ST_DONE;
          end else if (!fits) begin
            outcome <= scpa_pkg::OUT_DIRECT;
            direct_total <= direct_total + 32'd1;
            state <= scpa_pkg::ST_DONE;
          end else begin
            pool <= fit_pool;
            state <= scpa_pkg::ST_RDREQ;
          end
        end
        scpa_pkg::ST_RDREQ: begin
          if (stack_top[pool] != 7'd0) begin
            state <= scpa_pkg::ST_RDWT;
          end else if (room == 7'd0) begin
            outcome <= scpa_pkg::OUT_EXHAUSTED;
            error_total <= error_total + 32'd2;
            state <= scpa_pkg::ST_DONE;
          end else begin
            grow_left <= grow_n;
            next_grow[pool] <= (ng_dbl > 8'(BPP)) ? BPP7 : ng_dbl[6:0];
            grow_total <= grow_total + 32'd1;
            state <= scpa_pkg::ST_GROW;
          end
        end
        scpa_pkg::ST_GROW: begin
          if (grow_left == 7'd0) begin
            state <= scpa_pkg::ST_RDREQ;
          end else begin
            grow_left <= grow_left - 7'd1;
            stack_top[pool] <= stack_top[pool] + 7'd1;
            provisioned[pool] <= provisioned[pool] + 7'd1;
          end
        end
        scpa_pkg::ST_RDWT: begin
          stack_top[pool] <= stack_top[pool] - 7'd1;
          bytes_in_use <= (bytes_in_use > 32'hFFFFFFFF - cb) ? 32'hFFFFFFFF
                          : bytes_in_use + cb;
          if (((bytes_in_use > 32'hFFFFFFFF - cb) ? 32'hFFFFFFFF
               : bytes_in_use + cb) > peak_bytes)
            peak_bytes <= (bytes_in_use > 32'hFFFFFFFF - cb) ? 32'hFFFFFFFF
                          : bytes_in_use + cb;
          alloc_total <= alloc_total + 32'd1;
          granted_handle <= {pool, ram_rdata};
          outcome <= scpa_pkg::OUT_OK;
          state <= scpa_pkg::ST_DONE;
        end
        scpa_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          state <= scpa_pkg::ST_IDLE;
        end
        default: state <= scpa_pkg::ST_IDLE;
      endcase
    end
  end
endmodule

### rtl/scpa_checker.sv
// ----------------------------------------------------------------------------
// scpa_checker
// port level checks of the allocator core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  outcome,
  input logic [31:0] peak_bytes,
  input logic [31:0] bytes_in_use
);
  `ASSERT_CLK(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(outcome), "word dropped")
  `ASSERT_CLK(a_busy, clk, rst, out_valid |-> in_stall, "input taken while result pending")
  `ASSERT_CLK(a_peak, clk, rst, out_valid |-> peak_bytes >= bytes_in_use, "peak below bytes")
  `ASSERT_CLK(a_code, clk, rst, out_valid |-> outcome <= 3'd4, "bad outcome code")
  `ASSERT_CLK_RST(a_rst, clk, rst |=> !out_valid, "valid after reset")
endmodule
bind size_class_pool_allocator_core scpa_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .outcome(outcome),
  .peak_bytes(peak_bytes), .bytes_in_use(bytes_in_use)
);
